/* rtl/jms_pkg.sv */
// jms_pkg: shared types, widths and constant tables for the jet momentum sum block
// no dependencies; imported by every module under rtl
package jms_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int PT_W   = 16;
  localparam int ETA_W  = 12;
  localparam int PHI_W  = 16;
  localparam int SUM_W  = 40;
  localparam int JPT_W  = 32;
  localparam int CX_W   = 43;
  localparam int CZ_W   = 34;
  localparam int LOG_W  = 42;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int DIVN_W = 42;
  localparam int DIVD_W = 32;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic [19:0] GAIN_Q20 = 20'd636751;
  localparam logic [15:0] LN2_Q16  = 16'd45426;
  localparam logic [10:0] ETA_SAT  = 11'd2047;

  typedef struct packed {
    logic [PT_W-1:0]          pt;
    logic signed [ETA_W-1:0]  eta;
    logic signed [PHI_W-1:0]  phi;
    logic                     last_constituent;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  jet_px;
    logic signed [SUM_W-1:0]  jet_py;
    logic signed [SUM_W-1:0]  jet_pz;
    logic [JPT_W-1:0]         jet_pt;
    logic signed [ETA_W-1:0]  jet_eta;
    logic signed [PHI_W-1:0]  jet_phi;
    logic                     zero_pt;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic rot_mode;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // exp(2^k / 256) in q20
  function automatic logic [31:0] exp_val(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:  v = 32'd1052680;
      4'd1:  v = 32'd1056800;
      4'd2:  v = 32'd1065089;
      4'd3:  v = 32'd1081861;
      4'd4:  v = 32'd1116203;
      4'd5:  v = 32'd1188192;
      4'd6:  v = 32'd1346398;
      4'd7:  v = 32'd1728810;
      4'd8:  v = 32'd2850325;
      4'd9:  v = 32'd7747987;
      4'd10: v = 32'd57250310;
      4'd11: v = 32'd3125761002;
      default: v = 32'd1048576;
    endcase
    return v;
  endfunction

endpackage

/* rtl/jet_momentum_sum_top.sv */
// jet_momentum_sum_top: sequencer and datapath of the jet momentum accumulator
// depends on jms_pkg, jms_mul, jms_cordic, jms_div
// constituent: cordic rotation, x and y products, the exp chain and the divider, then the z product
// last constituent then adds vectoring, gain, log and eta steps (skipped when px and py are zero)
// one item at a time; in_ready is high only while the sequencer is idle
// reset (synchronous, rst_n low) clears the sums, the sequencer and out_valid
module jet_momentum_sum_top #(
  parameter int CORDIC_STEPS = jms_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jms_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jms_pkg::out_item_t   out_data
);
  import jms_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ROT   = 5'd1;
  localparam logic [4:0] S_MX    = 5'd2;
  localparam logic [4:0] S_MY    = 5'd3;
  localparam logic [4:0] S_AY    = 5'd4;
  localparam logic [4:0] S_EXP   = 5'd5;
  localparam logic [4:0] S_EXPW  = 5'd6;
  localparam logic [4:0] S_DIVS  = 5'd7;
  localparam logic [4:0] S_DIV   = 5'd8;
  localparam logic [4:0] S_MZ    = 5'd9;
  localparam logic [4:0] S_AZ    = 5'd10;
  localparam logic [4:0] S_FIN   = 5'd11;
  localparam logic [4:0] S_VEC   = 5'd12;
  localparam logic [4:0] S_G1    = 5'd13;
  localparam logic [4:0] S_G2    = 5'd14;
  localparam logic [4:0] S_G3    = 5'd15;
  localparam logic [4:0] S_LN    = 5'd16;
  localparam logic [4:0] S_LNORM = 5'd17;
  localparam logic [4:0] S_LSQ   = 5'd18;
  localparam logic [4:0] S_LSQW  = 5'd19;
  localparam logic [4:0] S_ETA   = 5'd20;
  localparam logic [4:0] S_ETAW  = 5'd21;
  localparam logic [4:0] S_EMIT  = 5'd22;

  localparam logic signed [CZ_W-1:0] QUARTER = CZ_W'(64'sd1073741824);
  localparam logic signed [CZ_W-1:0] HALF    = CZ_W'(64'sd2147483648);
  localparam logic signed [41:0] SMAX = 42'sd549755813887;
  localparam logic signed [41:0] SMIN = -42'sd549755813888;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [41:0] b);
    logic signed [41:0] s;
    s = 42'(a) + b;
    if (s > SMAX) return SUM_W'(SMAX);
    if (s < SMIN) return SUM_W'(SMIN);
    return SUM_W'(s);
  endfunction

  logic [4:0] state_r;
  in_item_t   item_r;
  logic       neg_r;
  logic signed [MUL_W-1:0] c_r, s_r;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] px_r, py_r, pz_r;
  logic [31:0] e_r;
  logic [3:0]  k_r;
  logic [30:0] sh_r;
  logic [SUM_W-1:0] apz_r;
  logic [LOG_W-1:0] ptf_r, m_r, gx_r, lm_r;
  logic [62:0] acc_r;
  logic        vec_pass_r, log_pass_r, zero_r;
  logic [5:0]  ln_n_r;
  logic [30:0] mant_r;
  logic [15:0] frac_r;
  logic [3:0]  sq_i_r;
  logic [21:0] la_r, d_r;
  logic signed [PHI_W-1:0] phi_res_r;
  logic signed [ETA_W-1:0] eta_res_r;
  out_item_t   out_r;
  logic        out_valid_r;

  logic accept;
  logic signed [CZ_W-1:0] t0, tf;
  logic fold;
  cordic_ctl_t cor_ctl;
  logic signed [CX_W-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [CZ_W-1:0] cor_z0, cor_z;
  logic cor_done;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic div_start, div_done;
  logic [DIVN_W-1:0] div_num, div_quo;
  logic [ETA_W-1:0] mag;
  logic signed [41:0] tx, dz;
  logic signed [SUM_W-1:0] sum_z_nxt;
  logic [62:0] gsum;
  logic [LOG_W-1:0] gres, lv;
  logic [31:0] sq;
  logic [15:0] frac_nxt;
  logic [21:0] lres;
  logic signed [CX_W-1:0] cx_abs;
  logic [14:0] em;
  logic [10:0] em_sat;
  logic zero_now;
  logic signed [CZ_W-1:0] zr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign t0   = {{(CZ_W-PHI_W-16){in_data.phi[PHI_W-1]}}, in_data.phi, 16'b0};
  assign fold = (t0 > QUARTER) || (t0 < -QUARTER);
  assign tf   = (t0 > QUARTER) ? t0 - HALF : ((t0 < -QUARTER) ? t0 + HALF : t0);

  assign mag      = item_r.eta[ETA_W-1] ? ETA_W'(-item_r.eta) : item_r.eta;
  assign tx       = 42'((prod_r + (PROD_W'(1) <<< 29)) >>> 30);
  assign dz       = item_r.eta[ETA_W-1] ? -42'((prod_r + (PROD_W'(1) <<< 19)) >>> 20)
                                        : 42'((prod_r + (PROD_W'(1) <<< 19)) >>> 20);
  assign sum_z_nxt = sat_add(sum_z_r, dz);
  assign gsum     = acc_r + (prod_r[62:0] << 21) + 63'd524288;
  assign gres     = gsum[61:20];
  assign lv       = log_pass_r ? ptf_r : (LOG_W'(apz_r) + m_r);
  assign sq       = prod_r[61:30];
  assign frac_nxt = {frac_r[14:0], sq[31]};
  assign lres     = {ln_n_r, frac_nxt};
  assign cx_abs   = cor_x[CX_W-1] ? '0 : cor_x;
  assign em       = 15'((prod_r[38:0] + 39'd8388608) >> 24);
  assign em_sat   = (em > 15'(ETA_SAT)) ? ETA_SAT : em[10:0];
  assign zero_now = (px_r == '0) && (py_r == '0);
  assign zr       = cor_z + CZ_W'(32768);
  assign div_start = (state_r == S_DIVS);
  assign div_num   = (DIVN_W'(1) << 40) + DIVN_W'(e_r >> 1);

  always_comb begin
    cor_ctl = '0;
    cor_x0  = '0;
    cor_y0  = '0;
    cor_z0  = '0;
    if (accept) begin
      cor_ctl = '{start: 1'b1, rot_mode: 1'b1};
      cor_x0  = CX_W'(GAIN_Q30);
      cor_z0  = tf;
    end else if (state_r == S_FIN && !zero_now) begin
      cor_ctl = '{start: 1'b1, rot_mode: 1'b0};
      cor_x0  = px_r[SUM_W-1] ? -CX_W'(px_r) : CX_W'(px_r);
      cor_y0  = px_r[SUM_W-1] ? -CX_W'(py_r) : CX_W'(py_r);
      cor_z0  = px_r[SUM_W-1] ? HALF : '0;
    end else if (state_r == S_G3 && !vec_pass_r) begin
      cor_ctl = '{start: 1'b1, rot_mode: 1'b0};
      cor_x0  = CX_W'(gres);
      cor_y0  = CX_W'(apz_r);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MX:  begin mul_a = MUL_W'(item_r.pt); mul_b = c_r; end
      S_MY:  begin mul_a = MUL_W'(item_r.pt); mul_b = s_r; end
      S_EXP: begin
        mul_a = MUL_W'(e_r);
        mul_b = mag[k_r] ? MUL_W'(exp_val(k_r)) : MUL_W'(33'd1048576);
      end
      S_MZ:  begin mul_a = MUL_W'(item_r.pt); mul_b = MUL_W'(sh_r); end
      S_G1:  begin mul_a = MUL_W'(gx_r[20:0]); mul_b = MUL_W'(GAIN_Q20); end
      S_G2:  begin mul_a = MUL_W'(gx_r[41:21]); mul_b = MUL_W'(GAIN_Q20); end
      S_LSQ: begin mul_a = MUL_W'(mant_r); mul_b = MUL_W'(mant_r); end
      S_ETA: begin mul_a = MUL_W'(d_r); mul_b = MUL_W'(LN2_Q16); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  jms_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  jms_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cor_ctl), .x0(cor_x0), .y0(cor_y0), .z0(cor_z0),
    .x_r(cor_x), .y_r(cor_y), .z_r(cor_z), .done_r(cor_done)
  );

  jms_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(e_r),
    .quo_r(div_quo), .done_r(div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            neg_r   <= fold;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (cor_done) begin
            c_r     <= neg_r ? MUL_W'(-cor_x) : MUL_W'(cor_x);
            s_r     <= neg_r ? MUL_W'(-cor_y) : MUL_W'(cor_y);
            state_r <= S_MX;
          end
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          sum_x_r <= sat_add(sum_x_r, tx);
          state_r <= S_AY;
        end
        S_AY: begin
          sum_y_r <= sat_add(sum_y_r, tx);
          e_r     <= 32'd1048576;
          k_r     <= '0;
          state_r <= S_EXP;
        end
        S_EXP: state_r <= S_EXPW;
        S_EXPW: begin
          e_r <= 32'((prod_r + (PROD_W'(1) <<< 19)) >>> 20);
          k_r <= k_r + 1'b1;
          state_r <= (k_r == 4'd11) ? S_DIVS : S_EXP;
        end
        S_DIVS: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            sh_r    <= 31'((e_r - div_quo[31:0]) >> 1);
            state_r <= S_MZ;
          end
        end
        S_MZ: state_r <= S_AZ;
        S_AZ: begin
          if (item_r.last_constituent) begin
            px_r    <= sum_x_r;
            py_r    <= sum_y_r;
            pz_r    <= sum_z_nxt;
            apz_r   <= sum_z_nxt[SUM_W-1] ? SUM_W'(-sum_z_nxt) : SUM_W'(sum_z_nxt);
            sum_x_r <= '0;
            sum_y_r <= '0;
            sum_z_r <= '0;
            state_r <= S_FIN;
          end else begin
            sum_z_r <= sum_z_nxt;
            state_r <= S_IDLE;
          end
        end
        S_FIN: begin
          zero_r     <= zero_now;
          vec_pass_r <= 1'b0;
          log_pass_r <= 1'b0;
          if (zero_now) begin
            ptf_r     <= '0;
            phi_res_r <= '0;
            eta_res_r <= (pz_r > 0) ? ETA_W'(ETA_SAT)
                       : ((pz_r < 0) ? -ETA_W'(ETA_SAT) : '0);
            state_r   <= S_EMIT;
          end else begin
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          if (cor_done) begin
            gx_r <= cx_abs[LOG_W-1:0];
            if (!vec_pass_r) phi_res_r <= zr[31:16];
            state_r <= S_G1;
          end
        end
        S_G1: state_r <= S_G2;
        S_G2: begin
          acc_r   <= prod_r[62:0];
          state_r <= S_G3;
        end
        S_G3: begin
          if (!vec_pass_r) begin
            ptf_r      <= gres;
            vec_pass_r <= 1'b1;
            state_r    <= S_VEC;
          end else begin
            m_r     <= gres;
            state_r <= S_LN;
          end
        end
        S_LN: begin
          lm_r    <= (lv == '0) ? LOG_W'(1) : lv;
          ln_n_r  <= 6'(LOG_W - 1);
          frac_r  <= '0;
          state_r <= S_LNORM;
        end
        S_LNORM: begin
          if (!lm_r[LOG_W-1]) begin
            lm_r   <= lm_r << 1;
            ln_n_r <= ln_n_r - 1'b1;
          end else begin
            mant_r  <= lm_r[LOG_W-1:LOG_W-31];
            sq_i_r  <= '0;
            state_r <= S_LSQ;
          end
        end
        S_LSQ: state_r <= S_LSQW;
        S_LSQW: begin
          mant_r <= sq[31] ? sq[31:1] : sq[30:0];
          frac_r <= frac_nxt;
          sq_i_r <= sq_i_r + 1'b1;
          if (sq_i_r == 4'd15) begin
            if (!log_pass_r) begin
              la_r       <= lres;
              log_pass_r <= 1'b1;
              state_r    <= S_LN;
            end else begin
              d_r     <= (la_r > lres) ? la_r - lres : '0;
              state_r <= S_ETA;
            end
          end else begin
            state_r <= S_LSQ;
          end
        end
        S_ETA: state_r <= S_ETAW;
        S_ETAW: begin
          eta_res_r <= pz_r[SUM_W-1] ? -ETA_W'(em_sat) : ETA_W'(em_sat);
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_r.jet_px  <= px_r;
            out_r.jet_py  <= py_r;
            out_r.jet_pz  <= pz_r;
            out_r.jet_pt  <= (ptf_r > LOG_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : ptf_r[31:0];
            out_r.jet_eta <= eta_res_r;
            out_r.jet_phi <= phi_res_r;
            out_r.zero_pt <= zero_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> sum_x_r == '0 && sum_y_r == '0 && sum_z_r == '0)
    else $error("sums not cleared at jet end");

  a_zero_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.zero_pt |-> out_r.jet_pt == '0 && out_r.jet_phi == '0)
    else $error("zero pt item with nonzero pt or phi");

  a_eta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.jet_eta != -12'sd2048)
    else $error("jet eta out of range");

  a_start_rot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_ROT)
    else $error("accepted item did not start rotation");

  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> state_r == S_ROT || state_r == S_VEC)
    else $error("cordic finished outside a waiting state");

endmodule

/* rtl/jms_mul.sv */
// jms_mul: registered signed multiplier shared by all product steps
// depends on jms_pkg
module jms_mul (
  input  logic                                clk,
  input  logic signed [jms_pkg::MUL_W-1:0]    a,
  input  logic signed [jms_pkg::MUL_W-1:0]    b,
  output logic signed [jms_pkg::PROD_W-1:0]   p_r
);
  import jms_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

/* rtl/jms_cordic.sv */
// jms_cordic: iterative circular cordic, rotation and vectoring, one step per cycle
// depends on jms_pkg (atan table, widths, control struct)
module jms_cordic #(
  parameter int STEPS = jms_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jms_pkg::cordic_ctl_t              ctl,
  input  logic signed [jms_pkg::CX_W-1:0]   x0,
  input  logic signed [jms_pkg::CX_W-1:0]   y0,
  input  logic signed [jms_pkg::CZ_W-1:0]   z0,
  output logic signed [jms_pkg::CX_W-1:0]   x_r,
  output logic signed [jms_pkg::CX_W-1:0]   y_r,
  output logic signed [jms_pkg::CZ_W-1:0]   z_r,
  output logic                              done_r
);
  import jms_pkg::*;

  localparam int N  = (STEPS > 32) ? 32 : STEPS;
  localparam int IW = $clog2(N + 1);

  logic          busy_r;
  logic          mode_r;
  logic [IW-1:0] i_r;
  logic [4:0]    idx;
  logic signed [CX_W-1:0] xs, ys;
  logic signed [CZ_W-1:0] at;
  logic          ccw;

  assign idx = 5'(i_r);
  assign xs  = x_r >>> idx;
  assign ys  = y_r >>> idx;
  assign at  = CZ_W'(atan_val(idx));
  assign ccw = mode_r ? !z_r[CZ_W-1] : y_r[CX_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == IW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_r <= ctl.rot_mode;
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
    end else if (busy_r) begin
      if (ccw) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

endmodule

/* rtl/jms_div.sv */
// jms_div: restoring divider, one quotient bit per cycle
// depends on jms_pkg (widths)
module jms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jms_pkg::DIVN_W-1:0]    num,
  input  logic [jms_pkg::DIVD_W-1:0]    den,
  output logic [jms_pkg::DIVN_W-1:0]    quo_r,
  output logic                          done_r
);
  import jms_pkg::*;

  localparam int CW = $clog2(DIVN_W + 1);

  logic [DIVD_W-1:0] den_r;
  logic [DIVD_W-1:0] rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic [DIVD_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DIVN_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? DIVD_W'(trial - {1'b0, den_r}) : trial[DIVD_W-1:0];
      quo_r <= {quo_r[DIVN_W-2:0], ge};
    end
  end

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for jet_momentum_sum_top, predicts each jet result in fixed point
// depends on jms_pkg and the rtl under rtl/
module tb;
  import jms_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int WATCH_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int watch_cnt = 0;

  longint sum_px = 0, sum_py = 0, sum_pz = 0;
  out_item_t jet_expect[$];

  longint unsigned atan_rom[32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};
  longint unsigned exp_rom[12] = '{
    64'd1052680, 64'd1056800, 64'd1065089, 64'd1081861, 64'd1116203, 64'd1188192,
    64'd1346398, 64'd1728810, 64'd2850325, 64'd7747987, 64'd57250310, 64'd3125761002};

  jet_momentum_sum_top #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic int step_count();
    return (STEPS > 32) ? 32 : STEPS;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > 64'sd549755813887) return 64'sd549755813887;
    if (r < -64'sd549755813888) return -64'sd549755813888;
    return r;
  endfunction

  function automatic longint cordic_mag(longint x, longint y, inout longint z);
    longint xs, ys;
    for (int i = 0; i < step_count(); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_rom[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_rom[i]);
      end
    end
    if (x < 0) x = 0;
    return (x * 636751 + (64'sd1 <<< 19)) >>> 20;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned v);
    int n;
    longint unsigned m, frac;
    n = 63;
    frac = 0;
    if (v == 0) v = 1;
    while (v[n] == 1'b0) n--;
    m = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
    for (int i = 0; i < 16; i++) begin
      frac = frac << 1;
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1; frac = frac | 1;
      end
    end
    return (longint'(n) << 16) | frac;
  endfunction

  task automatic predict_constituent(input in_item_t it);
    longint pt, eta, phi, t, x, y, xs, ys, c, s, dz, z, dummy, apz, m, ptf, eta_o, phi_o;
    longint px, py, pz;
    longint unsigned e, r, sh, la, lp, d, em;
    bit neg, zero;
    int mag;
    out_item_t res;
    pt = longint'({48'd0, it.pt});
    eta = longint'($signed(it.eta));
    phi = longint'($signed(it.phi));
    t = phi * 65536;
    x = 652032874;
    y = 0;
    neg = 0;
    if (t > 64'sd1073741824) begin
      t = t - 64'sd2147483648; neg = 1;
    end else if (t < -64'sd1073741824) begin
      t = t + 64'sd2147483648; neg = 1;
    end
    for (int i = 0; i < step_count(); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (t >= 0) begin
        x = x - ys; y = y + xs; t = t - longint'(atan_rom[i]);
      end else begin
        x = x + ys; y = y - xs; t = t + longint'(atan_rom[i]);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    mag = (eta < 0) ? int'(-eta) : int'(eta);
    e = 64'd1 << 20;
    for (int k = 0; k < 12; k++)
      if (mag[k]) e = (e * exp_rom[k] + (64'd1 << 19)) >> 20;
    r = ((64'd1 << 40) + e / 2) / e;
    sh = (e - r) >> 1;
    dz = longint'((longint'(pt) * sh + (64'd1 << 19)) >> 20);
    if (eta < 0) dz = -dz;
    sum_px = sat_sum(sum_px, (pt * c + (64'sd1 <<< 29)) >>> 30);
    sum_py = sat_sum(sum_py, (pt * s + (64'sd1 <<< 29)) >>> 30);
    sum_pz = sat_sum(sum_pz, dz);
    if (!it.last_constituent) return;
    px = sum_px; py = sum_py; pz = sum_pz;
    sum_px = 0; sum_py = 0; sum_pz = 0;
    zero = (px == 0 && py == 0);
    if (zero) begin
      ptf = 0;
      phi_o = 0;
      eta_o = (pz > 0) ? 2047 : ((pz < 0) ? -2047 : 0);
    end else begin
      x = px; y = py; z = 0; dummy = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd2147483648;
      end
      ptf = cordic_mag(x, y, z);
      phi_o = (z + 32768) >>> 16;
      apz = (pz < 0) ? -pz : pz;
      m = cordic_mag(ptf, apz, dummy);
      la = log2_fix(longint'(apz + m));
      lp = log2_fix(longint'(ptf));
      d = (la > lp) ? (la - lp) : 0;
      em = (d * 45426 + (64'd1 << 23)) >> 24;
      if (em > 2047) em = 2047;
      eta_o = (pz < 0) ? -longint'(em) : longint'(em);
    end
    res.jet_px = px[SUM_W-1:0];
    res.jet_py = py[SUM_W-1:0];
    res.jet_pz = pz[SUM_W-1:0];
    res.jet_pt = (ptf > 64'sd4294967295) ? 32'hFFFFFFFF : ptf[31:0];
    res.jet_eta = eta_o[ETA_W-1:0];
    res.jet_phi = phi_o[PHI_W-1:0];
    res.zero_pt = zero;
    jet_expect.insert(jet_expect.size(), res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  task automatic send_item(input logic [15:0] pt, input logic [11:0] eta,
                           input logic [15:0] phi, input logic last);
    in_item_t it;
    it.pt = pt; it.eta = eta; it.phi = phi; it.last_constituent = last;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = '0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    predict_constituent(it);
  endtask

  task automatic wait_jets_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (jet_expect.size() != 0) @(posedge clk);
  endtask

  task automatic send_jet(input int n);
    logic [11:0] eta;
    logic [15:0] pt;
    for (int i = 0; i < n; i++) begin
      pt = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      if ($urandom_range(7) == 0) eta = 12'($urandom);
      else eta = 12'($urandom_range(2560) - 1280);
      send_item(pt, eta, 16'($urandom), i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_item(16'd0, 12'd0, 16'd0, 1'b1);
    send_item(16'd65535, 12'd0, 16'd0, 1'b1);
    send_item(16'd65535, 12'h7FF, 16'h7FFF, 1'b1);
    send_item(16'd65535, 12'h800, 16'h8000, 1'b1);
    send_item(16'd1000, 12'd1280, 16'd16384, 1'b1);
    send_item(16'd1000, -12'sd1280, -16'sd16384, 1'b1);
    send_item(16'd400, 12'd300, 16'h8000, 1'b1);
    send_item(16'd100, 12'd256, 16'd0, 1'b0);
    send_item(16'd100, 12'd256, 16'h8000, 1'b1);
    send_item(16'd100, -12'sd256, 16'd0, 1'b0);
    send_item(16'd100, -12'sd256, 16'h8000, 1'b1);
    send_item(16'd1, 12'd0, 16'd16384, 1'b1);
    send_item(16'd50000, 12'd2000, 16'd8192, 1'b0);
    send_item(16'd50000, 12'd2000, 16'd9000, 1'b0);
    send_item(16'd0, 12'd5, 16'd77, 1'b1);
    send_item(16'd12345, -12'sd2000, 16'd40000, 1'b1);
    wait_jets_done();
  endtask

  task automatic test_random(input int sidle, input int ridle, input int items);
    int sent;
    int n;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      send_jet(n);
      sent += n;
    end
  endtask

  task automatic test_saturation();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 100; i++)
      send_item(16'd65535, 12'd2047, 16'($urandom), i == 99);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (jet_expect.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        out_item_t w;
        w = jet_expect.pop_front();
        if (out_data.jet_px !== w.jet_px) report_mismatch("jet_px", out_data.jet_px, w.jet_px);
        if (out_data.jet_py !== w.jet_py) report_mismatch("jet_py", out_data.jet_py, w.jet_py);
        if (out_data.jet_pz !== w.jet_pz) report_mismatch("jet_pz", out_data.jet_pz, w.jet_pz);
        if (out_data.jet_pt !== w.jet_pt) report_mismatch("jet_pt", out_data.jet_pt, w.jet_pt);
        if (out_data.jet_eta !== w.jet_eta)
          report_mismatch("jet_eta", out_data.jet_eta, w.jet_eta);
        if (out_data.jet_phi !== w.jet_phi)
          report_mismatch("jet_phi", out_data.jet_phi, w.jet_phi);
        if (out_data.zero_pt !== w.zero_pt)
          report_mismatch("zero_pt", out_data.zero_pt, w.zero_pt);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 50;
    test_directed();
    test_random(37, 50, 380);
    test_random(50, 37, 380);
    test_random(0, 0, 380);
    test_saturation();
    wait_jets_done();
    guard = 0;
    while (guard < 400) begin
      @(posedge clk);
      guard++;
    end
    if (err_count == 0 && jet_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
